// File: design/rpdt_pkg.sv
// ----------------------------------------------------------------------------
// Power domain table package
// Sizes, action codes, event codes and status codes for the refcounted
// power domain table.
// ----------------------------------------------------------------------------
package rpdt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int ID_W     = 16;
  localparam int EVENT_W  = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_UNREGISTER = 2'd1,
    ACT_DOWN_ALL   = 2'd2,
    ACT_UP_ALL     = 2'd3
  } action_t;

  // Result events.
  localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_UP      = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DOWN    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_STANDBY = 3'd3;
  localparam logic [EVENT_W-1:0] EV_SRESET  = 3'd4;

  // Result status.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NODEV = 2'd2;

endpackage

// File: design/refcounted_power_domain_table_top.sv
// ----------------------------------------------------------------------------
// Refcounted power domain table
// Steps: an accept step, a scan of up to TABLE_ENTRIES slots (one slot per cycle
// through a single compare unit), a finish step, then one final result.
// Sweeps also pass each emitted device result through the output register and
// wait for it to be taken before the scan goes on.
// Reset (synchronous) frees every slot, clears all counts and the down flag.
// ----------------------------------------------------------------------------
module refcounted_power_domain_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rpdt_pkg::ACTION_W-1:0] action,
  input  logic [rpdt_pkg::ID_W-1:0]     device_id,
  input  logic                          reset_instead,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rpdt_pkg::EVENT_W-1:0]  event_res,
  output logic [rpdt_pkg::ID_W-1:0]     target_id,
  output logic [rpdt_pkg::STATUS_W-1:0] status,
  output logic                          last
);
  import rpdt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_OUT
  } state_t;

  state_t state;

  // Table storage.
  logic [ID_W-1:0]    slot_ids    [TABLE_ENTRIES];
  logic [COUNT_W-1:0] slot_counts [TABLE_ENTRIES];
  logic               all_down;

  // Current transaction.
  action_t         cur_action;
  logic [ID_W-1:0] cur_id;
  logic            cur_reset;

  // Scan bookkeeping.
  logic [CNT_W-1:0] idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             pend_valid;
  logic [ID_W-1:0]  pend_id;

  // Shared compare unit on the slot under the scan pointer.
  logic [ID_W-1:0]    cur_entry;
  logic               entry_match;
  logic               entry_empty;
  logic               scan_end;
  logic [COUNT_W-1:0] sel_count;
  logic [COUNT_W-1:0] dec_count;
  logic               skip_scan;

  always_comb begin
    cur_entry   = slot_ids[idx[IDX_W-1:0]];
    entry_match = (cur_entry == cur_id);
    entry_empty = (cur_entry == '0);
    scan_end    = (idx == CNT_W'(TABLE_ENTRIES - 1));
    sel_count   = slot_counts[found_idx];
    dec_count   = (sel_count != '0) ? (sel_count - COUNT_W'(1)) : '0;
  end

  // Actions that need no slot walk go straight to the finish step.
  always_comb begin
    unique case (action_t'(action))
      ACT_REGISTER, ACT_UNREGISTER: skip_scan = (device_id == '0);
      ACT_DOWN_ALL:                 skip_scan = all_down;
      ACT_UP_ALL:                   skip_scan = !all_down;
      default:                      skip_scan = 1'b1;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer, table and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      all_down  <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_ids[i]    <= '0;
        slot_counts[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_action <= action_t'(action);
            cur_id     <= device_id;
            cur_reset  <= reset_instead;
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
            state      <= skip_scan ? S_FINISH : S_SCAN;
          end
        end

        S_SCAN: begin
          idx   <= idx + CNT_W'(1);
          state <= scan_end ? S_FINISH : S_SCAN;
          unique case (cur_action)
            ACT_REGISTER, ACT_UNREGISTER: begin
              if (entry_match && !found) begin
                found     <= 1'b1;
                found_idx <= idx[IDX_W-1:0];
              end
              if (entry_empty && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= idx[IDX_W-1:0];
              end
            end
            ACT_DOWN_ALL: begin
              if (!entry_empty) begin
                event_res <= EV_DOWN;
                target_id <= cur_entry;
                status    <= ST_OK;
                last      <= 1'b0;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end
            end
            ACT_UP_ALL: begin
              // Hold one device back so the final one can carry last.
              if (!entry_empty) begin
                pend_valid <= 1'b1;
                pend_id    <= cur_entry;
                if (pend_valid) begin
                  event_res <= EV_UP;
                  target_id <= pend_id;
                  status    <= ST_OK;
                  last      <= 1'b0;
                  out_valid <= 1'b1;
                  state     <= S_OUT;
                end
              end
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end

        S_FINISH: begin
          event_res <= EV_NONE;
          target_id <= '0;
          status    <= ST_OK;
          last      <= 1'b1;
          out_valid <= 1'b1;
          state     <= S_OUT;
          unique case (cur_action)
            ACT_REGISTER: begin
              if (cur_id == '0) begin
                status <= ST_NODEV;
              end else if (found) begin
                if (sel_count != COUNT_MAX) begin
                  slot_counts[found_idx] <= sel_count + COUNT_W'(1);
                end
              end else if (free_found) begin
                slot_ids[free_idx]    <= cur_id;
                slot_counts[free_idx] <= COUNT_W'(1);
                event_res             <= EV_UP;
                target_id             <= cur_id;
              end else begin
                status <= ST_FULL;
              end
            end
            ACT_UNREGISTER: begin
              if (cur_id == '0 || !found) begin
                status <= ST_NODEV;
              end else begin
                slot_counts[found_idx] <= dec_count;
                if (dec_count == '0) begin
                  slot_ids[found_idx] <= '0;
                  event_res           <= EV_DOWN;
                  target_id           <= cur_id;
                end
              end
            end
            ACT_DOWN_ALL: begin
              all_down  <= 1'b1;
              event_res <= cur_reset ? EV_SRESET : EV_STANDBY;
            end
            ACT_UP_ALL: begin
              all_down <= 1'b0;
              if (pend_valid) begin
                event_res <= EV_UP;
                target_id <= pend_id;
              end
            end
            default: begin
              status <= ST_OK;
            end
          endcase
        end

        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else if (idx == CNT_W'(TABLE_ENTRIES)) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/refcounted_power_domain_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power domain table checker
// Watches the request and result channels of the power domain table. It keeps
// its own copy of the device table, works out the power events each accepted
// request must cause, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module refcounted_power_domain_table_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [rpdt_pkg::ACTION_W-1:0] action,
  input  logic [rpdt_pkg::ID_W-1:0]     device_id,
  input  logic                          reset_instead,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [rpdt_pkg::EVENT_W-1:0]  event_res,
  input  logic [rpdt_pkg::ID_W-1:0]     target_id,
  input  logic [rpdt_pkg::STATUS_W-1:0] status,
  input  logic                          last,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_seen
);
  import rpdt_pkg::*;

  typedef struct {
    logic [EVENT_W-1:0]  event_res;
    logic [ID_W-1:0]     target_id;
    logic [STATUS_W-1:0] status;
    logic                last;
  } power_event_t;

  // Shadow copy of the device table and the domain-down flag.
  logic [ID_W-1:0]    shadow_id    [TABLE_ENTRIES];
  logic [COUNT_W-1:0] shadow_count [TABLE_ENTRIES];
  logic               shadow_down;

  // Power events still owed by the block, oldest first.
  power_event_t expected_events[$];

  function automatic void owe_event(input logic [EVENT_W-1:0] ev,
                                    input logic [ID_W-1:0] id,
                                    input logic [STATUS_W-1:0] st);
    power_event_t e;
    e.event_res = ev;
    e.target_id = id;
    e.status    = st;
    e.last      = 1'b0;
    expected_events.push_back(e);
  endfunction

  // Returns the first slot holding the id, or -1.
  function automatic int locate_device(input logic [ID_W-1:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && shadow_id[i] == id) hit = i;
    end
    return hit;
  endfunction

  // Updates the shadow table for one request and queues the events it causes.
  function automatic void apply_request(input action_t act,
                                        input logic [ID_W-1:0] id,
                                        input logic cpu_reset);
    int                  first_new;
    int                  hit;
    int                  free_slot;
    logic [STATUS_W-1:0] st;
    first_new = expected_events.size();
    st        = ST_OK;
    case (act)
      ACT_REGISTER: begin
        if (id == '0) begin
          st = ST_NODEV;
        end else begin
          hit = locate_device(id);
          if (hit >= 0) begin
            // Counts saturate instead of wrapping.
            if (shadow_count[hit] != COUNT_MAX) shadow_count[hit]++;
          end else begin
            free_slot = locate_device('0);
            if (free_slot >= 0) begin
              shadow_id[free_slot]    = id;
              shadow_count[free_slot] = COUNT_W'(1);
              owe_event(EV_UP, id, ST_OK);
            end else begin
              st = ST_FULL;
            end
          end
        end
      end
      ACT_UNREGISTER: begin
        hit = (id == '0) ? -1 : locate_device(id);
        if (hit < 0) begin
          st = ST_NODEV;
        end else begin
          if (shadow_count[hit] != 0) shadow_count[hit]--;
          if (shadow_count[hit] == 0) begin
            owe_event(EV_DOWN, id, ST_OK);
            shadow_id[hit] = '0;
          end
        end
      end
      ACT_DOWN_ALL: begin
        // A repeated sweep only repeats the CPU command.
        if (!shadow_down) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (shadow_id[i] != '0) owe_event(EV_DOWN, shadow_id[i], ST_OK);
          end
          shadow_down = 1'b1;
        end
        owe_event(cpu_reset ? EV_SRESET : EV_STANDBY, '0, ST_OK);
      end
      default: begin
        if (shadow_down) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (shadow_id[i] != '0) owe_event(EV_UP, shadow_id[i], ST_OK);
          end
          shadow_down = 1'b0;
        end
      end
    endcase
    // A request without a power event still answers with its status.
    if (expected_events.size() == first_new) owe_event(EV_NONE, '0, st);
    expected_events[expected_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    mismatches++;
  endfunction

  // Prediction on accepted requests, comparison on accepted results.
  always @(posedge clk) begin
    power_event_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        shadow_id[i]    = '0;
        shadow_count[i] = '0;
      end
      shadow_down = 1'b0;
      expected_events.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(action_t'(action), device_id, reset_instead);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual event %0d id %0d",
                   $time, event_res, target_id);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (event_res !== want.event_res) report_field("event_res", want.event_res, event_res);
          if (target_id !== want.target_id) report_field("target_id", want.target_id, target_id);
          if (status !== want.status) report_field("status", want.status, status);
          if (last !== want.last) report_field("last", want.last, last);
        end
      end
    end
    outstanding = expected_events.size();
  end

endmodule

// File: tb/sv/tb_refcounted_power_domain_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power domain table testbench
// Drives register, unregister and sweep requests into the power domain table
// with random gaps and result stalls: a directed walk through zero ids, table
// full and the down-flag cases, then random traffic over a small id pool.
// The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_refcounted_power_domain_table_top;
  import rpdt_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 3 * TABLE_ENTRIES + 10;
  localparam int POOL_SIZE = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  action_t             action = ACT_REGISTER;
  logic [ID_W-1:0]     device_id = '0;
  logic                reset_instead = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [EVENT_W-1:0]  event_res;
  logic [ID_W-1:0]     target_id;
  logic [STATUS_W-1:0] status;
  logic                last;

  int mismatches;
  int outstanding;
  int results_seen;
  int requests_sent = 0;
  int idle_cycles = 0;
  int result_stall = 0;
  logic result_taken = 1'b0;
  logic calm = 1'b0;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  always #5 clk = ~clk;

  refcounted_power_domain_table_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .device_id    (device_id),
    .reset_instead(reset_instead),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .target_id    (target_id),
    .status       (status),
    .last         (last)
  );

  refcounted_power_domain_table_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .device_id    (device_id),
    .reset_instead(reset_instead),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .target_id    (target_id),
    .status       (status),
    .last         (last),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // Result side: after each taken result, hold out_ready low for a random stall (none in the calm phase).
  always @(posedge clk) result_taken <= out_valid && out_ready;

  always @(negedge clk) begin
    if (result_taken) result_stall = calm ? 0 : $urandom_range(0, 12);
    if (result_stall > 0) begin
      out_ready <= 1'b0;
      result_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Presents one request after a random gap and waits for its transaction.
  task automatic push_request(input action_t act, input logic [ID_W-1:0] id,
                              input logic cpu_reset);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    device_id     <= id;
    reset_instead <= cpu_reset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Holds off requests until every owed result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    int slot;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero ids, unknown id and an idle power-up sweep on an empty table.
    push_request(ACT_REGISTER, 16'h0000, 1'b1);
    push_request(ACT_UNREGISTER, 16'h0000, 1'b0);
    push_request(ACT_UNREGISTER, 16'h1234, 1'b0);
    push_request(ACT_UP_ALL, 16'h0000, 1'b1);

    // Fill the table, then overflow it by one.
    push_request(ACT_REGISTER, 16'hFFFF, 1'b0);
    push_request(ACT_REGISTER, 16'h0001, 1'b0);
    push_request(ACT_REGISTER, 16'hAAAA, 1'b0);
    push_request(ACT_REGISTER, 16'h5555, 1'b1);
    push_request(ACT_REGISTER, 16'h8000, 1'b0);
    push_request(ACT_REGISTER, 16'h7FFF, 1'b0);
    push_request(ACT_REGISTER, 16'h0F0F, 1'b0);
    push_request(ACT_REGISTER, 16'hF0F0, 1'b0);
    push_request(ACT_REGISTER, 16'h1357, 1'b0);
    push_request(ACT_REGISTER, 16'hFFFF, 1'b0);

    // Full sweep down, repeated sweep, then table changes while down.
    push_request(ACT_DOWN_ALL, 16'h0000, 1'b0);
    push_request(ACT_DOWN_ALL, 16'hFFFF, 1'b1);
    push_request(ACT_UNREGISTER, 16'h0001, 1'b0);
    push_request(ACT_REGISTER, 16'h2468, 1'b0);
    push_request(ACT_UP_ALL, 16'h0000, 1'b0);
    push_request(ACT_UP_ALL, 16'h0000, 1'b0);
    push_request(ACT_UNREGISTER, 16'hFFFF, 1'b1);
    push_request(ACT_UNREGISTER, 16'hFFFF, 1'b0);

    // Free the remaining directed devices so random traffic has room.
    push_request(ACT_UNREGISTER, 16'hAAAA, 1'b0);
    push_request(ACT_UNREGISTER, 16'h5555, 1'b0);
    push_request(ACT_UNREGISTER, 16'h8000, 1'b0);
    push_request(ACT_UNREGISTER, 16'h7FFF, 1'b0);
    push_request(ACT_UNREGISTER, 16'h0F0F, 1'b0);
    push_request(ACT_UNREGISTER, 16'hF0F0, 1'b0);
    push_request(ACT_UNREGISTER, 16'h2468, 1'b0);
    settle();

    // Random traffic over a small id pool, so ids repeat and the table fills.
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(1, 65535));
    for (int phase = 0; phase < 3; phase++) begin
      calm = (phase == 1);
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, POOL_SIZE - 1);
        if (pick < 40) begin
          push_request(ACT_REGISTER, id_pool[slot], 1'($urandom_range(0, 1)));
        end else if (pick < 72) begin
          push_request(ACT_UNREGISTER, id_pool[slot], 1'($urandom_range(0, 1)));
        end else if (pick < 81) begin
          push_request(ACT_DOWN_ALL, ID_W'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
        end else if (pick < 90) begin
          push_request(ACT_UP_ALL, ID_W'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)));
        end else if (pick < 95) begin
          push_request(ACT_UNREGISTER, ID_W'($urandom_range(1, 65535)),
                       1'($urandom_range(0, 1)));
        end else begin
          push_request(action_t'($urandom_range(0, 1)), 16'h0000,
                       1'($urandom_range(0, 1)));
        end
      end
      if (phase == 0) settle();
    end

    // Wait out every owed result plus a margin for stray ones.
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d requests (directed zero-id, table-full and sweep cases, then",
             requests_sent);
    $display("random pool traffic); %0d results were checked.", results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rpdt_pkg.sv
design/refcounted_power_domain_table_top.sv
tb/sv/refcounted_power_domain_table_checker.sv
tb/sv/tb_refcounted_power_domain_table_top.sv
